// ----- rtl/tkst_pkg.sv -----
// ----------------------------------------------------------------------------
// tkst_pkg: shared types and constants of the top-K score table
// Record layout, command and status groups between controller and datapath,
// and register map constants.
// ----------------------------------------------------------------------------
package tkst_pkg;

	localparam int SCORE_W  = 24;
	localparam int LEVEL_W  = 10;
	localparam int HEALTH_W = 8;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Register index of the level threshold, taken from paddr[2].
	localparam logic REG_LEVEL_THRESHOLD = 1'b0;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(200);

	typedef struct packed {
		logic [HEALTH_W-1:0] health;
		logic [LEVEL_W-1:0]  level;
		logic [SCORE_W-1:0]  score;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the offered record
		logic insert;  // compare and shift the table
		logic flag;    // evaluate level flags per entry
		logic finish;  // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;  // output register holds a result that is not taken
	} status_t;

endpackage

// ----- rtl/top_k_sorted_score_table.sv -----
// ----------------------------------------------------------------------------
// top_k_sorted_score_table: table of the best records by descending score
// An accepted item passes the insert and flag steps and waits in the done
// state while the previous result is still untaken; then its result moves into
// the output register. A new item is taken only in the idle state, after the
// controller's load, insert, flag and finish steps over the single table.
// Reset: asynchronous; all entries clear to zero and the threshold to 200.
// ----------------------------------------------------------------------------
module top_k_sorted_score_table
	import tkst_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// Input records.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,   // new_score[23:0], new_level[33:24],
	                                     // new_health[41:34], zero fill
	// Results.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // accepted[0], high_level_present[1],
	                                     // zero fill
	// Configuration.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cmd_t               cmd;
	status_t            status;
	entry_t             in_entry;
	logic [LEVEL_W-1:0] level_threshold;
	logic               out_accepted;
	logic               out_high_level;

	// Unpack the offered record from the stream word.
	assign in_entry.score  = s_tdata[SCORE_W-1:0];
	assign in_entry.level  = s_tdata[SCORE_W+LEVEL_W-1:SCORE_W];
	assign in_entry.health = s_tdata[SCORE_W+LEVEL_W+HEALTH_W-1:SCORE_W+LEVEL_W];

	// The threshold register must be written only while the block is idle, so
	// the flag step always sees a settled value; the block does not enforce this.
	tkst_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.level_threshold(level_threshold)
	);

	// The controller steps one item at a time through the datapath. The
	// output register lets a new item enter while a result still waits.
	tkst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	// Every entry compares against the offered score in parallel; the
	// entries at and below the insert position shift down by one.
	tkst_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_entry       (in_entry),
		.level_threshold(level_threshold),
		.m_tready       (m_tready),
		.m_tvalid       (m_tvalid),
		.out_accepted   (out_accepted),
		.out_high_level (out_high_level)
	);

	assign m_tdata = {6'b0, out_high_level, out_accepted};

endmodule

// ----- rtl/tkst_cfg.sv -----
// ----------------------------------------------------------------------------
// tkst_cfg: configuration register block
// APB-style write and read of the level threshold register.
// ----------------------------------------------------------------------------
module tkst_cfg
	import tkst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [LEVEL_W-1:0] level_threshold
);

	logic [LEVEL_W-1:0] thr_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (wr_en && paddr[2] == REG_LEVEL_THRESHOLD) begin
			thr_q <= pwdata[LEVEL_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LEVEL_THRESHOLD: prdata = {{(DATA_W-LEVEL_W){1'b0}}, thr_q};
			default:             prdata = '0;
		endcase
	end

	assign level_threshold = thr_q;

endmodule

// ----- rtl/tkst_ctrl.sv -----
// ----------------------------------------------------------------------------
// tkst_ctrl: sequencing controller
// Steps one record through load, insert, flag and finish.
// ----------------------------------------------------------------------------
module tkst_ctrl
	import tkst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  logic    m_tready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_INSERT = 4'b0010,
		S_FLAG   = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_free;

	assign out_free = !status.out_busy || m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_INSERT;
				end
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = S_FLAG;
			end
			S_FLAG: begin
				cmd.flag = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A result never overwrites one that is still waiting.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!status.out_busy || m_tready))
		else $error("finish while output register is occupied");

	a_accept_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_INSERT))
		else $error("accepted item did not start its insert step");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one command issued in a cycle");

endmodule

// ----- rtl/tkst_dp.sv -----
// ----------------------------------------------------------------------------
// tkst_dp: table datapath
// Holds the sorted entries, performs the parallel compare and shift insert,
// evaluates the level flags and keeps the output register.
// ----------------------------------------------------------------------------
module tkst_dp
	import tkst_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  entry_t             in_entry,
	input  logic [LEVEL_W-1:0] level_threshold,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic               out_accepted,
	output logic               out_high_level
);

	entry_t                   entry_q [TABLE_DEPTH];
	entry_t                   new_q;
	logic [TABLE_DEPTH-1:0]   lt;
	logic [TABLE_DEPTH-1:0]   hi_q;
	logic                     acc_q;
	logic                     out_valid_q;
	logic                     out_acc_q;
	logic                     out_hlp_q;

	// lt is monotone because the table is sorted: it is set from the insert
	// position down to the last entry.
	always_comb begin
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			lt[k] = (entry_q[k].score < new_q.score);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_q <= in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				entry_q[k] <= '0;
			end
		end else if (cmd.insert && lt[TABLE_DEPTH-1]) begin
			if (lt[0]) begin
				entry_q[0] <= new_q;
			end
			for (int k = 1; k < TABLE_DEPTH; k++) begin
				if (lt[k]) begin
					if (!lt[k-1]) begin
						entry_q[k] <= new_q;
					end else begin
						entry_q[k] <= entry_q[k-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			acc_q <= lt[TABLE_DEPTH-1];
		end
		if (cmd.flag) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				hi_q[k] <= (entry_q[k].level >= level_threshold);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_acc_q <= acc_q;
			out_hlp_q <= |hi_q;
		end
	end

	assign status.out_busy = out_valid_q;
	assign m_tvalid        = out_valid_q;
	assign out_accepted    = out_acc_q;
	assign out_high_level  = out_hlp_q;

	// The table stays in descending score order at all times.
	for (genvar g = 0; g < TABLE_DEPTH - 1; g++) begin : g_sorted
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			entry_q[g].score >= entry_q[g+1].score)
			else $error("score table out of order");
	end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the top-K sorted score table
// Offers score records on the input stream. A scoreboard keeps its own copy
// of the table and the level threshold and predicts one result per
// record: whether the record entered the table and whether any stored level
// reaches the threshold. The threshold register is written over APB between
// phases, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
	import tkst_pkg::*;

	localparam int DEPTH = 16;

	// Register map: the threshold at byte address 0. The next word holds no
	// register, so a write to it must leave the threshold alone.
	localparam logic [ADDR_W-1:0] ADDR_LEVEL_THRESHOLD = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] ADDR_UNUSED          = ADDR_W'(4);

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 92;
	// Time the block gets to settle after the last result has come back.
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 400000;

	// One predicted result, packed in the same order as the output tdata.
	typedef struct packed {
		logic high_level;
		logic accepted;
	} outcome_t;

	// Tracks the table contents and the threshold, and holds the results
	// that are still owed by the block, oldest first.
	class score_table_sb;
		entry_t             rows[DEPTH];
		logic [LEVEL_W-1:0] threshold;
		outcome_t           pending_outcomes[$];
		int                 errors;
		int                 offered;
		int                 entered;
		int                 high_seen;
		int                 checked;

		function new();
			foreach (rows[k]) rows[k] = '0;
			threshold = THRESHOLD_RESET;
			errors    = 0;
			offered   = 0;
			entered   = 0;
			high_seen = 0;
			checked   = 0;
		endfunction

		function void flag_error(string what, int unsigned want, int unsigned got);
			errors++;
			if (errors <= 10) begin
				$display("MISMATCH %s: expected %0d, got %0d", what, want, got);
			end
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction

		function logic [SCORE_W-1:0] lowest_score();
			return rows[DEPTH-1].score;
		endfunction

		// Apply one accepted input record to the table and queue its result.
		function void note_record(logic [SCORE_W-1:0] sc, logic [LEVEL_W-1:0] lv,
				logic [HEALTH_W-1:0] hp);
			outcome_t o;
			int       slot;
			bit       found;
			o.accepted   = rows[DEPTH-1].score < sc;
			o.high_level = 1'b0;
			if (o.accepted) begin
				// The record goes after every entry whose score is at least
				// its own; everything below moves down and the last drops out.
				slot  = DEPTH - 1;
				found = 1'b0;
				for (int k = 0; k < DEPTH; k++) begin
					if (!found && rows[k].score < sc) begin
						slot  = k;
						found = 1'b1;
					end
				end
				for (int k = DEPTH - 1; k > slot; k--) rows[k] = rows[k-1];
				rows[slot].score  = sc;
				rows[slot].level  = lv;
				rows[slot].health = hp;
				entered++;
			end
			// Empty entries count with level zero.
			foreach (rows[k]) begin
				if (rows[k].level >= threshold) o.high_level = 1'b1;
			end
			offered++;
			pending_outcomes.push_back(o);
		endfunction

		function void check_result(logic [7:0] data);
			outcome_t want;
			checked++;
			if (pending_outcomes.size() == 0) begin
				flag_error("result with nothing outstanding", 0, data);
				return;
			end
			want = pending_outcomes.pop_front();
			if (want.high_level) high_seen++;
			if (data[0] !== want.accepted) flag_error("accepted", want.accepted, data[0]);
			if (data[1] !== want.high_level) begin
				flag_error("high_level_present", want.high_level, data[1]);
			end
		endfunction
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [47:0]       s_tdata = '0;    // new_score[23:0], new_level[33:24],
	                                    // new_health[41:34], zero fill
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;         // accepted[0], high_level_present[1],
	                                    // zero fill
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	score_table_sb sb;

	// Idling controls, changed from phase to phase by the stimulus.
	int gap_max    = 2;
	int stall_pct  = 25;
	int burst_left = 1;
	int stall_left = 0;
	int settings_written = 0;
	int unsigned cycle_count = 0;

	// Per-phase threshold, longest sender gap and receiver stall chance.
	// A threshold of -1 picks a random value.
	int phase_thr[PHASES]   = '{1023, 0, 1022, 600, -1, 150, 1, -1};
	int phase_gap[PHASES]   = '{0, 3, 8, 1, 20, 0, 5, 2};
	int phase_stall[PHASES] = '{0, 20, 50, 0, 70, 10, 30, 90};

	top_k_sorted_score_table #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, sb.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: ready unless in a stall; outside a stall it may start a stall of a
	// random length. The chance of a stall is set per phase, zero in some phases.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_left = $urandom_range(11);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Both handshakes are sampled at the clock edge, before any driver's
	// update of that edge takes effect. An input item is noted before a
	// result of the same edge is checked; a result never comes that fast.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_record(s_tdata[23:0], s_tdata[33:24], s_tdata[41:34]);
			end
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
		end
	end

	// Offer one record and hold it until the block takes it. Records go out
	// in bursts; valid only drops when a gap actually follows the burst.
	task automatic offer(input logic [SCORE_W-1:0] sc, input logic [LEVEL_W-1:0] lv,
			input logic [HEALTH_W-1:0] hp);
		int gap;
		s_tdata  <= {6'd0, hp, lv, sc};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(16, 1);
			gap = $urandom_range(gap_max);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering and wait until every predicted result has come back,
	// then give the block time to settle. The first wait lets the
	// monitor note an item taken at the current edge.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// Only the threshold word holds a register; its upper bits are dropped.
		if (addr == ADDR_LEVEL_THRESHOLD) sb.threshold = data[LEVEL_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_threshold();
		logic [DATA_W-1:0] got;
		apb_read(ADDR_LEVEL_THRESHOLD, got);
		if (got !== DATA_W'(sb.threshold)) sb.flag_error("threshold readback", sb.threshold, got);
	endtask

	// Random junk goes into the bits above the register width.
	task automatic write_threshold(input int value);
		logic [DATA_W-1:0] data;
		data = $urandom();
		data[LEVEL_W-1:0] = LEVEL_W'(value);
		apb_write(ADDR_LEVEL_THRESHOLD, data);
		settings_written++;
	endtask

	// Scores mostly land around the current smallest entry, so that ties,
	// near misses and narrow wins keep happening once the table is full.
	// The rest are full-range scores, exact copies of the smallest, and zero.
	function automatic logic [SCORE_W-1:0] pick_score();
		int kind;
		int base;
		int step;
		kind = $urandom_range(99);
		if (kind < 10) return SCORE_W'($urandom());
		if (kind < 16) return sb.lowest_score();
		if (kind < 19) return '0;
		step = $urandom_range(12);
		base = int'(sb.lowest_score()) + step - 4;
		if (base < 0) base = 0;
		if (base > 24'hFFFFFF) base = 24'hFFFFFF;
		return SCORE_W'(base);
	endfunction

	// Levels sit mostly below the threshold so the flag can fall back to
	// zero; some hit the threshold exactly or one below it.
	function automatic logic [LEVEL_W-1:0] pick_level(input logic [LEVEL_W-1:0] thr);
		int kind;
		kind = $urandom_range(99);
		if (kind < 10) return thr;
		if (kind < 15) return (thr == 0) ? thr : thr - LEVEL_W'(1);
		if (kind < 25) return LEVEL_W'($urandom());
		if (thr == 0) return '0;
		return LEVEL_W'($urandom_range(int'(thr) - 1));
	endfunction

	initial begin
		int thr;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The threshold must come out of reset at its default.
		check_threshold();

		// Directed part, on the default threshold. A zero score against an
		// empty table is turned away, as is any score equal to the smallest.
		offer(24'd0, 10'd1023, 8'd255);
		offer(24'hFFFFFF, 10'd0, 8'd255);
		offer(24'd1, 10'd1023, 8'd0);
		// Three equal scores: each new one must land behind the others.
		offer(24'd500, 10'd199, 8'h55);
		offer(24'd500, 10'd200, 8'hAA);
		offer(24'd500, 10'd201, 8'h0F);
		for (int k = 0; k < 10; k++) offer(SCORE_W'(100 + 7 * k), LEVEL_W'(50 * k), HEALTH_W'(k));
		// One entry is still empty, so the next record fills it; after that
		// the table is full and the smallest score is 1.
		offer(24'd3, 10'd0, 8'd0);
		offer(24'd1, 10'd5, 8'd1);
		offer(24'd2, 10'd6, 8'd2);
		offer(24'd2, 10'd7, 8'd3);
		offer(24'd0, 10'd0, 8'd0);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			thr = (phase_thr[p] < 0) ? $urandom_range(1023) : phase_thr[p];
			write_threshold(thr);
			check_threshold();
			if (p == 4) begin
				apb_write(ADDR_UNUSED, $urandom());
				check_threshold();
			end
			gap_max   = phase_gap[p];
			stall_pct = phase_stall[p];
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Once in the run the sender holds off until the block has
				// returned every result.
				if (p == 2 && i == ITEMS_PER_PHASE / 2) drain();
				offer(pick_score(), pick_level(sb.threshold), HEALTH_W'($urandom()));
			end
		end
		drain();

		$display("Offered %0d records, %0d entered the table, %0d results checked",
			sb.offered, sb.entered, sb.checked);
		$display("%0d results flagged a high level over %0d threshold settings",
			sb.high_seen, settings_written);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- top_k_sorted_score_table.f -----
rtl/tkst_pkg.sv
rtl/tkst_cfg.sv
rtl/tkst_ctrl.sv
rtl/tkst_dp.sv
rtl/top_k_sorted_score_table.sv
tb/tb_top.sv
